// File: rtl/tns_pkg.sv
// Shared types, constants and a helper function for the tick to nanosecond scaler.
// No dependencies; every other file of the block but tns_checker imports this package.
package tns_pkg;

  localparam int unsigned TickW         = 64;
  localparam int unsigned RatioW        = 32;
  localparam int unsigned CfgIdxW       = 4;
  localparam int unsigned DivBitsPerStg = 4;
  localparam int unsigned DivStages     = TickW / DivBitsPerStg;
  localparam int unsigned ShiftW        = $clog2(RatioW);

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegNumer = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegDenom = CfgIdxW'(1);

  // Magnitude limits of a signed 64-bit result.
  localparam logic [TickW-1:0] PosLimit    = {1'b0, {(TickW-1){1'b1}}};
  localparam logic [TickW-1:0] NegLimitMag = {1'b1, {(TickW-1){1'b0}}};

  typedef enum logic [1:0] {
    RdIdle,
    RdStart,
    RdGcd,
    RdDiv
  } rd_state_e;

  // Reduced fraction handed from the reduction unit to the datapath.
  typedef struct packed {
    logic [RatioW-1:0] numer;
    logic [RatioW-1:0] denom;
    logic              busy;
  } ratio_t;

  // Sideband that travels with an item through a divider pipeline.
  typedef struct packed {
    logic [TickW-1:0] acc;
    logic             neg;
    logic             nc;
    logic             sat;
  } side_t;

  typedef struct packed {
    logic [TickW-1:0] ns;
    logic             sat;
    logic             nc;
  } res_t;

  // Several restoring division steps: returns {remainder, shifted dividend/quotient}.
  function automatic logic [RatioW+TickW-1:0] div_step(input logic [RatioW-1:0] rem,
                                                       input logic [TickW-1:0]  qd,
                                                       input logic [RatioW-1:0] dv);
    logic [RatioW:0]   t;
    logic [RatioW-1:0] r;
    logic [TickW-1:0]  q;
    r = rem;
    q = qd;
    for (int i = 0; i < int'(DivBitsPerStg); i++) begin
      t = {r, q[TickW-1]};
      q = {q[TickW-2:0], 1'b0};
      if (t >= {1'b0, dv}) begin
        t    = t - {1'b0, dv};
        q[0] = 1'b1;
      end
      r = t[RatioW-1:0];
    end
    return {r, q};
  endfunction

endpackage

// File: rtl/tns_reduce.sv
// Configuration registers and the multi-cycle fraction reduction unit
// (binary GCD, then radix-2 division of both values by the GCD). Depends on tns_pkg.
module tns_reduce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [tns_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tns_pkg::RatioW-1:0]    cfg_data_i,
  output tns_pkg::ratio_t               ratio_o
);
  import tns_pkg::*;

  rd_state_e         state_q, state_d;
  logic [RatioW-1:0] numer_q, numer_d, denom_q, denom_d;
  logic [RatioW-1:0] red_n_q, red_n_d, red_d_q, red_d_d;
  logic [RatioW-1:0] a_q, a_d, b_q, b_d, g_q, g_d;
  logic [ShiftW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic [RatioW-1:0] rn_q, rn_d, rd_q, rd_d, qn_q, qn_d, qd_q, qd_d;
  logic [RatioW:0]   tn, td;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RdIdle;
      numer_q <= '0;
      denom_q <= '0;
      red_n_q <= '0;
      red_d_q <= '0;
    end else begin
      state_q <= state_d;
      numer_q <= numer_d;
      denom_q <= denom_d;
      red_n_q <= red_n_d;
      red_d_q <= red_d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    g_q   <= g_d;
    k_q   <= k_d;
    cnt_q <= cnt_d;
    rn_q  <= rn_d;
    rd_q  <= rd_d;
    qn_q  <= qn_d;
    qd_q  <= qd_d;
  end

  always_comb begin
    state_d = state_q;
    numer_d = numer_q;
    denom_d = denom_q;
    red_n_d = red_n_q;
    red_d_d = red_d_q;
    a_d     = a_q;
    b_d     = b_q;
    g_d     = g_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    rn_d    = rn_q;
    rd_d    = rd_q;
    qn_d    = qn_q;
    qd_d    = qd_q;
    tn      = {rn_q, qn_q[RatioW-1]};
    td      = {rd_q, qd_q[RatioW-1]};

    unique case (state_q)
      RdIdle: begin
      end
      RdStart: begin
        if (numer_q == '0 || denom_q == '0) begin
          red_n_d = '0;
          red_d_d = '0;
          state_d = RdIdle;
        end else begin
          a_d     = numer_q;
          b_d     = denom_q;
          k_d     = '0;
          state_d = RdGcd;
        end
      end
      RdGcd: begin
        if (a_q == b_q) begin
          g_d     = a_q << k_q;
          qn_d    = numer_q;
          qd_d    = denom_q;
          rn_d    = '0;
          rd_d    = '0;
          cnt_d   = '0;
          state_d = RdDiv;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q > b_q) begin
          a_d = a_q - b_q;
        end else begin
          b_d = b_q - a_q;
        end
      end
      RdDiv: begin
        qn_d = {qn_q[RatioW-2:0], 1'b0};
        qd_d = {qd_q[RatioW-2:0], 1'b0};
        if (tn >= {1'b0, g_q}) begin
          tn      = tn - {1'b0, g_q};
          qn_d[0] = 1'b1;
        end
        if (td >= {1'b0, g_q}) begin
          td      = td - {1'b0, g_q};
          qd_d[0] = 1'b1;
        end
        rn_d  = tn[RatioW-1:0];
        rd_d  = td[RatioW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == {ShiftW{1'b1}}) begin
          red_n_d = qn_d;
          red_d_d = qd_d;
          state_d = RdIdle;
        end
      end
      default: state_d = RdIdle;
    endcase

    // A register write restarts the reduction from the new values.
    if (cfg_valid_i && cfg_index_i == RegNumer) begin
      numer_d = cfg_data_i;
      state_d = RdStart;
    end else if (cfg_valid_i && cfg_index_i == RegDenom) begin
      denom_d = cfg_data_i;
      state_d = RdStart;
    end
  end

  assign ratio_o.numer = red_n_q;
  assign ratio_o.denom = red_d_q;
  assign ratio_o.busy  = (state_q != RdIdle);

endmodule

// File: rtl/tns_divpipe.sv
// Pipelined unsigned 64 by 32 bit restoring divider, a few quotient bits per stage.
// Depends on tns_pkg (widths, side_t and div_step).
module tns_divpipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [tns_pkg::TickW-1:0]   dividend_i,
  input  logic [tns_pkg::RatioW-1:0]  divisor_i,
  input  tns_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [tns_pkg::TickW-1:0]   quot_o,
  output logic [tns_pkg::RatioW-1:0]  rem_o,
  output tns_pkg::side_t              side_o
);
  import tns_pkg::*;

  logic              vld_q  [DivStages];
  logic [RatioW-1:0] rem_q  [DivStages];
  logic [TickW-1:0]  qd_q   [DivStages];
  side_t             side_q [DivStages];

  for (genvar s = 0; s < int'(DivStages); s++) begin : g_stage
    logic              v_in;
    logic [RatioW-1:0] rem_in;
    logic [TickW-1:0]  qd_in;
    side_t             side_in;
    logic [RatioW+TickW-1:0] step;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign qd_in   = dividend_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign qd_in   = qd_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign step = div_step(rem_in, qd_in, divisor_i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= step[RatioW+TickW-1:TickW];
        qd_q[s]   <= step[TickW-1:0];
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[DivStages-1];
  assign quot_o  = qd_q[DivStages-1];
  assign rem_o   = rem_q[DivStages-1];
  assign side_o  = side_q[DivStages-1];

endmodule

// File: rtl/tick_to_ns_fraction_scaler_top.sv
// Top level of the tick to nanosecond fraction scaler.
// Depends on tns_pkg, tns_reduce and tns_divpipe.
//
// Usage:
// - Configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i):
//   index 0 writes the numerator, index 1 the denominator, other indexes are
//   ignored. cfg_ready_o is always high. A write starts the reduction of the
//   fraction by its greatest common divisor (binary GCD, then division);
//   while it runs in_ready_o is low. The user makes writes only while no item
//   is in flight; the block itself does not enforce this.
// - Input channel (in_valid_i/in_ready_o, tick_count_i) takes one item per
//   cycle while no reduction runs and the skid register is empty. Each item
//   passes an input register, a 16 stage divider by the denominator, a
//   product stage, a saturation stage, a second 16 stage divider for the
//   fractional part and the output register that drives out_valid_o.
// - Output channel (out_valid_o/out_ready_i) carries nanoseconds_o with the
//   saturated_o and not_configured_o flags.
// - When the receiver stalls, an item leaving the pipeline parks in a skid
//   register, and the pipeline freezes while it is full, so nothing is lost.
// - Reset clears both registers and the reduced fraction, so items give
//   not_configured_o until both registers hold nonzero values.
module tick_to_ns_fraction_scaler_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tns_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tns_pkg::RatioW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [63:0]          tick_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [63:0]          nanoseconds_o,
  output logic                        saturated_o,
  output logic                        not_configured_o
);
  import tns_pkg::*;

  ratio_t ratio;
  logic   en;

  // Configuration and reduction.
  tns_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ratio_o     (ratio)
  );

  assign cfg_ready_o = 1'b1;

  // Output register plus skid register. The pipeline advances only while
  // the skid register is empty, which keeps out_ready_i off the enable path.
  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q, res_new;
  logic res_new_valid;

  assign en         = !skid_valid_q;
  assign in_ready_o = en && !ratio.busy;

  // Stage 0: sign and magnitude of the tick count.
  logic             v0_q;
  logic [TickW-1:0] mag0_q;
  side_t            side0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i && in_ready_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag0_q      <= tick_count_i[63] ? TickW'(-tick_count_i) : TickW'(tick_count_i);
      side0_q.acc <= '0;
      side0_q.neg <= tick_count_i[63];
      side0_q.nc  <= (ratio.numer == '0) || (ratio.denom == '0);
      side0_q.sat <= 1'b0;
    end
  end

  // First divider: magnitude of quotient and remainder by the denominator.
  logic              v1;
  logic [TickW-1:0]  quot1;
  logic [RatioW-1:0] rem1;
  side_t             side1;

  tns_divpipe u_div_int (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v0_q),
    .dividend_i (mag0_q),
    .divisor_i  (ratio.denom),
    .side_i     (side0_q),
    .valid_o    (v1),
    .quot_o     (quot1),
    .rem_o      (rem1),
    .side_o     (side1)
  );

  // Stage 2: three 32 by 32 products, the quotient split in halves.
  logic             v2_q;
  logic [TickW-1:0] pr_q, pqlo_q, pqhi_q;
  side_t            side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q    <= TickW'(rem1) * TickW'(ratio.numer);
      pqlo_q  <= TickW'(quot1[RatioW-1:0]) * TickW'(ratio.numer);
      pqhi_q  <= TickW'(quot1[TickW-1:RatioW]) * TickW'(ratio.numer);
      side2_q <= side1;
    end
  end

  // Stage 3: saturate the quotient and remainder products to the sign's limit.
  localparam int unsigned FullW = TickW + RatioW;
  logic [TickW-1:0] limit3, qmag3, rclip3;
  logic [FullW-1:0] qfull3;
  logic             rsat3, qsat3;
  logic             v3_q;
  logic [TickW-1:0] rclip_q;
  side_t            side3_q;

  always_comb begin
    limit3 = side2_q.neg ? NegLimitMag : PosLimit;
    qfull3 = {pqhi_q, {RatioW{1'b0}}} + FullW'(pqlo_q);
    qsat3  = qfull3 > FullW'(limit3);
    rsat3  = pr_q > limit3;
    qmag3  = qsat3 ? limit3 : qfull3[TickW-1:0];
    rclip3 = rsat3 ? limit3 : pr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rclip_q     <= rclip3;
      side3_q.acc <= side2_q.neg ? -qmag3 : qmag3;
      side3_q.neg <= side2_q.neg;
      side3_q.nc  <= side2_q.nc;
      side3_q.sat <= qsat3 || rsat3;
    end
  end

  // Second divider: fractional nanoseconds from the scaled remainder.
  logic              v4;
  logic [TickW-1:0]  frac4;
  logic [RatioW-1:0] rem4;
  side_t             side4;

  tns_divpipe u_div_frac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v3_q),
    .dividend_i (rclip_q),
    .divisor_i  (ratio.denom),
    .side_i     (side3_q),
    .valid_o    (v4),
    .quot_o     (frac4),
    .rem_o      (rem4),
    .side_o     (side4)
  );

  // Final saturating add of the integer and fractional parts. The remainder
  // of this division is not needed.
  logic [TickW-1:0] fval;
  logic [TickW:0]   sum;
  logic             ovf;

  always_comb begin
    fval = side4.neg ? -frac4 : frac4;
    sum  = {side4.acc[TickW-1], side4.acc} + {fval[TickW-1], fval};
    ovf  = sum[TickW] != sum[TickW-1];
    res_new_valid = v4;
    if (side4.nc) begin
      res_new.ns  = '0;
      res_new.sat = 1'b0;
      res_new.nc  = 1'b1;
    end else begin
      res_new.ns  = ovf ? (sum[TickW] ? NegLimitMag : PosLimit) : sum[TickW-1:0];
      res_new.sat = side4.sat || ovf || (rem4 == '1 && 1'b0);
      res_new.nc  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !out_ready_i) begin
      skid_valid_q <= res_new_valid;
    end else begin
      out_valid_q <= res_new_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (out_valid_q && !out_ready_i) begin
      skid_q <= res_new;
    end else begin
      out_q <= res_new;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign nanoseconds_o    = out_q.ns;
  assign saturated_o      = out_q.sat;
  assign not_configured_o = out_q.nc;

endmodule

// File: rtl/tns_checker.sv
// Port-level checker for the tick to nanosecond scaler and its bind statement.
// Depends on tick_to_ns_fraction_scaler_top.
module tns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [3:0]  cfg_index_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] nanoseconds_o,
  input logic        saturated_o,
  input logic        not_configured_o
);

  a_nc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && not_configured_o |-> nanoseconds_o == 64'd0 && !saturated_o)
    else $error("not configured item carries a nonzero result");

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i == 4'd0 || cfg_index_i == 4'd1)
    |=> !in_ready_o)
    else $error("input accepted while the fraction is being reduced");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(nanoseconds_o) && $stable(saturated_o))
    else $error("output item changed while stalled");

endmodule

bind tick_to_ns_fraction_scaler_top tns_checker u_tns_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cfg_valid_i      (cfg_valid_i),
  .cfg_ready_o      (cfg_ready_o),
  .cfg_index_i      (cfg_index_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .nanoseconds_o    (nanoseconds_o),
  .saturated_o      (saturated_o),
  .not_configured_o (not_configured_o)
);

// File: tb/tick_to_ns_fraction_scaler_checker.sv
// Checker for the tick to nanosecond fraction scaler: watches all channels, predicts each result.
// Depends on tns_pkg for the register indexes and port widths.
module tick_to_ns_fraction_scaler_checker
  import tns_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [RatioW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic signed [63:0]  tick_count_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic signed [63:0]  nanoseconds_i,
  input  logic                saturated_i,
  input  logic                not_configured_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint NsMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint NsMin = 64'sh8000_0000_0000_0000;

  typedef struct {
    longint ns;
    bit     sat;
    bit     nc;
  } ns_result_t;

  logic [RatioW-1:0] numer_reg, denom_reg, red_numer, red_denom;
  ns_result_t        expected_ns_q[$];

  function automatic longint clip_mul(longint a, longint k, inout bit clipped);
    if (a < NsMin / k || NsMax / k < a) begin
      clipped = 1'b1;
      return (a >= 0) ? NsMax : NsMin;
    end
    return a * k;
  endfunction

  function automatic longint clip_add(longint a, longint b, inout bit clipped);
    if (b > 0 && a > NsMax - b) begin
      clipped = 1'b1;
      return NsMax;
    end
    if (b < 0 && a < NsMin - b) begin
      clipped = 1'b1;
      return NsMin;
    end
    return a + b;
  endfunction

  function automatic ns_result_t scale_ticks(longint ticks);
    ns_result_t res;
    longint     mul, dv, quo, rem, part;
    bit         clipped;
    clipped = 1'b0;
    res.ns  = 0;
    res.sat = 1'b0;
    res.nc  = 1'b0;
    if (red_numer == '0 || red_denom == '0) begin
      res.nc = 1'b1;
      return res;
    end
    mul = longint'({32'b0, red_numer});
    dv  = longint'({32'b0, red_denom});
    if (dv == 1) begin
      res.ns = clip_mul(ticks, mul, clipped);
    end else begin
      quo    = ticks / dv;
      rem    = ticks % dv;
      part   = clip_mul(rem, mul, clipped) / dv;
      res.ns = clip_add(clip_mul(quo, mul, clipped), part, clipped);
    end
    res.sat = clipped;
    return res;
  endfunction

  // Reduce the fraction by its greatest common divisor after each register write.
  task automatic reduce_ratio();
    logic [RatioW-1:0] a, b, t;
    if (numer_reg == '0 || denom_reg == '0) begin
      red_numer = '0;
      red_denom = '0;
      return;
    end
    a = numer_reg;
    b = denom_reg;
    while (b != '0) begin
      t = b;
      b = a % b;
      a = t;
    end
    red_numer = numer_reg / a;
    red_denom = denom_reg / a;
  endtask

  assign pending_o = expected_ns_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    ns_result_t want;
    if (!rst_ni) begin
      numer_reg    = '0;
      denom_reg    = '0;
      red_numer    = '0;
      red_denom    = '0;
      fail_count_o = 0;
      expected_ns_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegNumer) begin
          numer_reg = cfg_data_i;
          reduce_ratio();
        end else if (cfg_index_i == RegDenom) begin
          denom_reg = cfg_data_i;
          reduce_ratio();
        end
      end
      if (in_valid_i && in_ready_i) expected_ns_q.push_back(scale_ticks(tick_count_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_ns_q.size() == 0) begin
          $display("%0t: unexpected item ns=%0d sat=%0b nc=%0b", $time, nanoseconds_i,
                   saturated_i, not_configured_i);
          fail_count_o++;
        end else begin
          want = expected_ns_q.pop_front();
          if (nanoseconds_i !== want.ns) begin
            $display("%0t: nanoseconds expected %0d actual %0d", $time, want.ns, nanoseconds_i);
            fail_count_o++;
          end
          if (saturated_i !== want.sat) begin
            $display("%0t: saturated expected %0b actual %0b", $time, want.sat, saturated_i);
            fail_count_o++;
          end
          if (not_configured_i !== want.nc) begin
            $display("%0t: not_configured expected %0b actual %0b", $time, want.nc,
                     not_configured_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

// File: tb/tick_to_ns_fraction_scaler_top_tb.sv
// Top of the testbench: clock, reset, stimulus through several ratio settings, and the verdict.
// Depends on tns_pkg, the scaler RTL and tick_to_ns_fraction_scaler_checker.
module tick_to_ns_fraction_scaler_top_tb;
  import tns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is stopped here at the latest, far beyond the slowest correct run.
  localparam int CycleLimit = 1_000_000;
  // This margin covers the pipeline and the skid register.
  localparam int DrainCycles = 50;
  localparam int ItemsPerPhase = 105;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [RatioW-1:0]  cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [63:0] tick_count_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [63:0] nanoseconds_o;
  logic               saturated_o;
  logic               not_configured_o;

  int fail_count;
  int pending;
  int cycle_count;
  // When clear, neither side inserts idle cycles (used in the final phase).
  bit idling_on;
  logic [RatioW-1:0] cur_denom;

  tick_to_ns_fraction_scaler_top u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .tick_count_i, .out_valid_o, .out_ready_i,
    .nanoseconds_o, .saturated_o, .not_configured_o
  );

  tick_to_ns_fraction_scaler_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .tick_count_i,
    .out_valid_i(out_valid_o), .out_ready_i, .nanoseconds_i(nanoseconds_o),
    .saturated_i(saturated_o), .not_configured_i(not_configured_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The cycle counter is the only timeout; it ends the run with the fail message.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver stalls in random bursts while idling is enabled, and is otherwise ready.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      if (idling_on) repeat ($urandom_range(0, 20)) @(posedge clk_i);
    end
  end

  // Writes one register. The channel is sampled at the falling edge so that the
  // handshake is judged on stable values.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RatioW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == RegDenom) cur_denom = val;
  endtask

  // Sends one tick count. The caller is at a rising edge or just after the
  // previous acceptance, so valid is raised by a single assignment per step.
  task automatic send_ticks(input logic signed [63:0] ticks);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    tick_count_i <= ticks;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  // Random tick counts, weighted toward the limits and toward values near
  // multiples of the denominator, where truncation and carries matter.
  function automatic logic signed [63:0] rand_ticks();
    logic signed [63:0] v;
    logic signed [63:0] den;
    den = (cur_denom == '0) ? 64'sd1 : $signed({32'b0, cur_denom});
    case ($urandom_range(0, 6))
      0, 1: v = {$urandom, $urandom};
      2: v = $signed(64'($urandom_range(0, 4000))) - 64'sd2000;
      3: v = 64'sh7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1 << 20));
      4: v = 64'sh8000_0000_0000_0000 + 64'($urandom_range(0, 1 << 20));
      5: v = den * $signed(64'($urandom_range(0, 1 << 16)) - 64'sd32768)
             + $signed(64'($urandom_range(0, 4))) - 64'sd2;
      default: v = $signed({32'b0, $urandom}) >>> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 7) == 0) v = -v;
    return v;
  endfunction

  // Directed values: zero, unit steps, both limits, values around the denominator, bit patterns.
  task automatic send_directed();
    logic signed [63:0] den;
    den = $signed({32'b0, cur_denom});
    send_ticks(64'sd0);
    send_ticks(64'sd1);
    send_ticks(-64'sd1);
    send_ticks(64'sh7FFF_FFFF_FFFF_FFFF);
    send_ticks(64'sh8000_0000_0000_0000);
    send_ticks(64'sh8000_0000_0000_0001);
    send_ticks(den);
    send_ticks(den - 1);
    send_ticks(-den + 1);
    send_ticks(-den);
    send_ticks(64'sh5555_5555_5555_5555);
    send_ticks(64'shAAAA_AAAA_AAAA_AAAA);
  endtask

  // Waits until every expected item has arrived and the pipeline is drained.
  // Valid drops at the edge that accepted the last item.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [RatioW-1:0] numer, input logic [RatioW-1:0] denom,
                           input bit directed);
    write_reg(RegNumer, numer);
    write_reg(RegDenom, denom);
    @(posedge clk_i);
    if (directed) send_directed();
    repeat (ItemsPerPhase) send_ticks(rand_ticks());
    wait_drained();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    tick_count_i = '0;
    idling_on    = 1'b1;
    cur_denom    = '0;
    cycle_count  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Straight out of reset every item must report the ratio as unconfigured.
    @(posedge clk_i);
    repeat (20) send_ticks(rand_ticks());
    wait_drained();

    // Typical counter frequency, then a denominator of one (plain multiply).
    run_phase(32'd1_000_000_000, 32'd19_200_000, 1'b1);
    run_phase(32'd1_000_000_000, 32'd1, 1'b1);
    run_phase(32'hFFFF_FFFF, 32'd1, 1'b1);
    // Largest numerator and denominator; equal values reduce to one over one.
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    run_phase(32'd1, 32'hFFFF_FFFF, 1'b1);
    run_phase(32'hFFFF_FFFE, 32'd3, 1'b1);
    run_phase(32'd2_000_000_000, 32'd24_000_000, 1'b0);

    // A zero numerator with a valid denominator gives unconfigured results.
    run_phase(32'd0, 32'd7, 1'b1);

    // Writes to indexes beyond the register list must not change the ratio.
    write_reg(RegNumer, 32'd125);
    write_reg(RegDenom, 32'd3);
    write_reg(CfgIdxW'(2), 32'hFFFF_FFFF);
    write_reg(CfgIdxW'(15), 32'h0000_0000);
    cur_denom = 32'd3;
    @(posedge clk_i);
    repeat (ItemsPerPhase) send_ticks(rand_ticks());
    wait_drained();

    // Final phase runs without idling on either side.
    idling_on = 1'b0;
    run_phase(32'd1_000_000_000, 32'd10_000_000, 1'b0);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
